// ----- sv/rfs_pkg.sv -----
// Shared types, constants and the CRC-24Q byte step for the RTCM3 frame synchroniser.
`default_nettype none

package rfs_pkg;

	localparam int unsigned FILL_W   = 11;
	localparam int unsigned QDEPTH   = 2;

	localparam logic        OP_PUSH  = 1'b0;
	localparam logic        OP_READ  = 1'b1;

	localparam logic [7:0]  SYNC_BYTE      = 8'hD3;
	localparam logic [7:0]  RESERVED_MASK  = 8'hFC;
	localparam logic [7:0]  LEN_HI_MASK    = 8'h03;
	localparam logic [10:0] FRAME_OVERHEAD = 11'd6;
	localparam logic [10:0] CRC_BYTES      = 11'd3;
	localparam logic [10:0] RESV_FILL      = 11'd2;
	localparam logic [23:0] CRC24Q_POLY    = 24'h864CFB;

	typedef enum logic [2:0] {
		ST_INCOMPLETE = 3'd0,
		ST_DISCARD    = 3'd1,
		ST_VALID      = 3'd2,
		ST_FULL       = 3'd3,
		ST_READ       = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_H0,
		S_H1,
		S_H2,
		S_H3,
		S_EVAL,
		S_CRC,
		S_CRCCHK,
		S_SHIFT,
		S_EMIT
	} engine_state_t;

	typedef enum logic [1:0] {
		EV_INCOMPLETE,
		EV_DISCARD,
		EV_CRC
	} eval_t;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  data_byte;
		logic [10:0] read_index;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [10:0] frame_length;
		logic [7:0]  read_data;
		logic [10:0] buffer_fill;
	} res_t;

	function automatic logic [23:0] crc24q_step(input logic [23:0] crc, input logic [7:0] data);
		logic [23:0] c;
		logic        msb;
		c = crc ^ {data, 16'h0000};
		for (int i = 0; i < 8; i++) begin
			msb = c[23];
			c = {c[22:0], 1'b0};
			if (msb) begin
				c = c ^ CRC24Q_POLY;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- sv/rfs_queue.sv -----
// Two-word queue used between the ports and the frame engine.
`default_nettype none

module rfs_queue #(
	parameter int unsigned WIDTH = 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int unsigned PW = $clog2(rfs_pkg::QDEPTH);
	localparam int unsigned CW = $clog2(rfs_pkg::QDEPTH + 1);

	logic [WIDTH-1:0] slot_q [rfs_pkg::QDEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(rfs_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(rfs_pkg::QDEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(rfs_pkg::QDEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- sv/rfs_engine.sv -----
// Frame engine: frame store, header check, CRC-24Q walk and discard shift.
`default_nettype none

module rfs_engine #(
	parameter int unsigned MAX_FRAME_BYTES = 1029
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire rfs_pkg::cmd_t cmd,
	output logic               cmd_pop,
	input  wire logic          res_full,
	output logic               res_push,
	output rfs_pkg::res_t      res
);

	localparam int unsigned AW = $clog2(MAX_FRAME_BYTES);
	localparam logic [rfs_pkg::FILL_W-1:0] MAX_FILL = rfs_pkg::FILL_W'(MAX_FRAME_BYTES);

	rfs_pkg::engine_state_t state_q, state_d;

	logic [7:0]                store_q [MAX_FRAME_BYTES];
	logic [7:0]                rdata_q;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [7:0]                mem_wdata;
	logic [AW-1:0]             mem_raddr;

	logic [rfs_pkg::FILL_W-1:0] fill_q;
	logic [rfs_pkg::FILL_W-1:0] ptr_q;
	logic [rfs_pkg::FILL_W-1:0] dptr_s1;
	logic                       dval_s1;
	logic [rfs_pkg::FILL_W-1:0] need_q;
	logic [rfs_pkg::FILL_W-1:0] lim_q;
	logic [7:0]                 b0_q, b1_q, b2_q;
	logic [23:0]                crc_q;
	logic [23:0]                given_q;
	logic                       rd_ok_q;
	rfs_pkg::res_t              res_q;

	logic [rfs_pkg::FILL_W-1:0] hdr_len;
	logic [rfs_pkg::FILL_W-1:0] hdr_need;
	logic [rfs_pkg::FILL_W-1:0] dprev;
	rfs_pkg::eval_t             ev;
	logic                       crc_issue;
	logic                       shift_issue;
	logic                       crc_last;
	logic                       push_ok;

	assign hdr_len     = {1'b0, b1_q[1:0] & rfs_pkg::LEN_HI_MASK[1:0], b2_q};
	assign hdr_need    = hdr_len + rfs_pkg::FRAME_OVERHEAD;
	assign dprev       = dptr_s1 - rfs_pkg::FILL_W'(1);
	assign crc_issue   = (ptr_q < need_q);
	assign shift_issue = (ptr_q <= fill_q);
	assign crc_last    = dval_s1 && (dptr_s1 == need_q - rfs_pkg::FILL_W'(1));
	assign push_ok     = (fill_q < MAX_FILL);
	assign res         = res_q;

	always_comb begin
		if (b0_q != rfs_pkg::SYNC_BYTE) begin
			ev = rfs_pkg::EV_DISCARD;
		end else if ((fill_q >= rfs_pkg::RESV_FILL) && ((b1_q & rfs_pkg::RESERVED_MASK) != 8'h00)) begin
			ev = rfs_pkg::EV_DISCARD;
		end else if (fill_q < rfs_pkg::FRAME_OVERHEAD) begin
			ev = rfs_pkg::EV_INCOMPLETE;
		end else if ((hdr_len == '0) || (hdr_need > MAX_FILL)) begin
			ev = rfs_pkg::EV_DISCARD;
		end else if (fill_q < hdr_need) begin
			ev = rfs_pkg::EV_INCOMPLETE;
		end else begin
			ev = rfs_pkg::EV_CRC;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rfs_pkg::S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.opcode == rfs_pkg::OP_READ) begin
						state_d = rfs_pkg::S_RD;
					end else if (push_ok) begin
						state_d = rfs_pkg::S_H0;
					end else begin
						state_d = rfs_pkg::S_EMIT;
					end
				end
			end
			rfs_pkg::S_RD:  state_d = rfs_pkg::S_EMIT;
			rfs_pkg::S_H0:  state_d = rfs_pkg::S_H1;
			rfs_pkg::S_H1:  state_d = rfs_pkg::S_H2;
			rfs_pkg::S_H2:  state_d = rfs_pkg::S_H3;
			rfs_pkg::S_H3:  state_d = rfs_pkg::S_EVAL;
			rfs_pkg::S_EVAL: begin
				unique case (ev)
					rfs_pkg::EV_DISCARD: state_d = rfs_pkg::S_SHIFT;
					rfs_pkg::EV_CRC:     state_d = rfs_pkg::S_CRC;
					default:             state_d = rfs_pkg::S_EMIT;
				endcase
			end
			rfs_pkg::S_CRC: begin
				if (crc_last) begin
					state_d = rfs_pkg::S_CRCCHK;
				end
			end
			rfs_pkg::S_CRCCHK: begin
				state_d = (crc_q == given_q) ? rfs_pkg::S_EMIT : rfs_pkg::S_SHIFT;
			end
			rfs_pkg::S_SHIFT: begin
				if (!shift_issue && !dval_s1) begin
					state_d = rfs_pkg::S_EMIT;
				end
			end
			rfs_pkg::S_EMIT: begin
				if (!res_full) begin
					state_d = rfs_pkg::S_IDLE;
				end
			end
			default: state_d = rfs_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = fill_q[AW-1:0];
		mem_wdata = cmd.data_byte;
		mem_raddr = ptr_q[AW-1:0];
		unique case (state_q)
			rfs_pkg::S_IDLE: begin
				cmd_pop   = cmd_valid;
				mem_raddr = cmd.read_index[AW-1:0];
				mem_we    = cmd_valid && (cmd.opcode == rfs_pkg::OP_PUSH) && push_ok;
			end
			rfs_pkg::S_H0: mem_raddr = AW'(0);
			rfs_pkg::S_H1: mem_raddr = AW'(1);
			rfs_pkg::S_H2: mem_raddr = AW'(2);
			rfs_pkg::S_SHIFT: begin
				mem_we    = dval_s1;
				mem_waddr = dprev[AW-1:0];
				mem_wdata = rdata_q;
			end
			rfs_pkg::S_EMIT: res_push = !res_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= store_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfs_pkg::S_IDLE;
			fill_q  <= '0;
			dval_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			dval_s1 <= 1'b0;
			unique case (state_q)
				rfs_pkg::S_IDLE: begin
					if (mem_we) begin
						fill_q <= fill_q + rfs_pkg::FILL_W'(1);
					end
				end
				rfs_pkg::S_EVAL: begin
					if (ev == rfs_pkg::EV_DISCARD) begin
						fill_q <= fill_q - rfs_pkg::FILL_W'(1);
					end
				end
				rfs_pkg::S_CRC:   dval_s1 <= crc_issue;
				rfs_pkg::S_CRCCHK: begin
					fill_q <= (crc_q == given_q) ? '0 : fill_q - rfs_pkg::FILL_W'(1);
				end
				rfs_pkg::S_SHIFT: dval_s1 <= shift_issue;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			rfs_pkg::S_IDLE: begin
				rd_ok_q <= (cmd.read_index < MAX_FILL);
				res_q   <= '{status: rfs_pkg::ST_FULL, frame_length: '0, read_data: '0,
				             buffer_fill: fill_q};
			end
			rfs_pkg::S_RD: begin
				res_q <= '{status: rfs_pkg::ST_READ, frame_length: '0,
				           read_data: rd_ok_q ? rdata_q : 8'h00, buffer_fill: fill_q};
			end
			rfs_pkg::S_H1: b0_q <= rdata_q;
			rfs_pkg::S_H2: b1_q <= rdata_q;
			rfs_pkg::S_H3: b2_q <= rdata_q;
			rfs_pkg::S_EVAL: begin
				need_q <= hdr_need;
				lim_q  <= hdr_len + rfs_pkg::CRC_BYTES;
				crc_q  <= '0;
				ptr_q  <= (ev == rfs_pkg::EV_DISCARD) ? rfs_pkg::FILL_W'(1) : '0;
				res_q  <= '{status: rfs_pkg::ST_INCOMPLETE, frame_length: '0, read_data: '0,
				            buffer_fill: fill_q};
			end
			rfs_pkg::S_CRC: begin
				if (crc_issue) begin
					ptr_q   <= ptr_q + rfs_pkg::FILL_W'(1);
					dptr_s1 <= ptr_q;
				end
				if (dval_s1) begin
					if (dptr_s1 < lim_q) begin
						crc_q <= rfs_pkg::crc24q_step(crc_q, rdata_q);
					end else begin
						given_q <= {given_q[15:0], rdata_q};
					end
				end
			end
			rfs_pkg::S_CRCCHK: begin
				ptr_q <= rfs_pkg::FILL_W'(1);
				res_q <= '{status: rfs_pkg::ST_VALID, frame_length: need_q, read_data: '0,
				           buffer_fill: '0};
			end
			rfs_pkg::S_SHIFT: begin
				if (shift_issue) begin
					ptr_q   <= ptr_q + rfs_pkg::FILL_W'(1);
					dptr_s1 <= ptr_q;
				end
				res_q <= '{status: rfs_pkg::ST_DISCARD, frame_length: '0, read_data: '0,
				           buffer_fill: fill_q};
			end
			default: ;
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= MAX_FILL)
		else $error("fill count beyond store depth");

	a_valid_res: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && (res.status == rfs_pkg::ST_VALID) |->
			(res.buffer_fill == '0) && (res.frame_length > rfs_pkg::FRAME_OVERHEAD))
		else $error("valid frame word with bad length or fill");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && (res.status != rfs_pkg::ST_VALID) |-> (res.frame_length == '0))
		else $error("frame length set on a non-valid word");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == rfs_pkg::S_IDLE) || (state_q == rfs_pkg::S_SHIFT))
		else $error("store written outside push or shift");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfs_pkg::S_IDLE) && mem_we |=> (fill_q == $past(fill_q) + rfs_pkg::FILL_W'(1)))
		else $error("push did not advance the fill count");

endmodule

`default_nettype wire

// ----- sv/rtcm3_frame_synchronizer.sv -----
// Top level of the RTCM3 frame synchroniser: input queue, frame engine, result queue.
//
//   channel | handshake        | words
//   --------+------------------+------------------------------------------------
//   input   | push / full      | opcode, data_byte, read_index
//   result  | empty / pop      | status, frame_length, read_data, buffer_fill
//
// A discarded leading byte adds a shift that moves the remaining bytes down by one.
// A complete frame of total length N walks its N bytes through the single store read port;
// when the CRC fails, a discard shift follows.
// Reset clears fill count and control only; the store needs no clearing pass.
// Both sides stall on their own through two-word queues on input and result.
`default_nettype none

module rtcm3_frame_synchronizer #(
	parameter int unsigned MAX_FRAME_BYTES = 1029
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        opcode,
	input  wire logic [7:0]  data_byte,
	input  wire logic [10:0] read_index,
	output logic             empty,
	input  wire logic        pop,
	output logic [2:0]       status,
	output logic [10:0]      frame_length,
	output logic [7:0]       read_data,
	output logic [10:0]      buffer_fill
);

	rfs_pkg::cmd_t cmd_in;
	rfs_pkg::cmd_t cmd_out;
	logic          cmd_empty;
	logic          cmd_pop;
	rfs_pkg::res_t res_in;
	rfs_pkg::res_t res_out;
	logic          res_full;
	logic          res_push;
	logic [$bits(rfs_pkg::cmd_t)-1:0] cmd_vec;
	logic [$bits(rfs_pkg::res_t)-1:0] res_vec;

	assign cmd_in  = '{opcode: opcode, data_byte: data_byte, read_index: read_index};
	assign cmd_out = rfs_pkg::cmd_t'(cmd_vec);
	assign res_out = rfs_pkg::res_t'(res_vec);

	rfs_queue #(
		.WIDTH($bits(rfs_pkg::cmd_t))
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_vec),
		.empty (cmd_empty)
	);

	rfs_engine #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	rfs_queue #(
		.WIDTH($bits(rfs_pkg::res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_vec),
		.empty (empty)
	);

	assign status       = res_out.status;
	assign frame_length = res_out.frame_length;
	assign read_data    = res_out.read_data;
	assign buffer_fill  = res_out.buffer_fill;

endmodule

`default_nettype wire

// ----- tb/sv/rtcm3_frame_synchronizer_tb.sv -----
// Self-checking testbench for the RTCM3 frame synchroniser: directed table, then random frames, noise bytes and reads.
module rtcm3_frame_synchronizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_BYTES   = 1029;
	localparam int unsigned ITEM_TARGET = 570;
	localparam int unsigned LONG_SEQ    = 30;
	localparam int unsigned LONG_LEN    = 250;
	localparam int unsigned TAIL_CYCLES = 2200;
	localparam int unsigned N_DIR       = 22;

	typedef logic [7:0] octet_q_t[$];

	typedef enum logic [1:0] {USE_BYTE, CRC_HI, CRC_MID, CRC_LO} byte_src_t;
	typedef enum logic [1:0] {POP_FREE, POP_HALF, POP_SPARSE, POP_HOLD} pop_mode_t;

	typedef struct packed {
		logic          op;
		logic [7:0]    b;
		logic [10:0]   idx;
		byte_src_t     src;
		logic          typed;
		rfs_pkg::res_t want;
	} dir_row_t;

	localparam rfs_pkg::res_t NO_WANT = '{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd0};

	// header D3 00 01, payload FF, CRC filled in from the store when driven
	dir_row_t dir_rows [N_DIR] = '{
		'{rfs_pkg::OP_READ, 8'hFF, 11'h7FF, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_READ, 11'd0, 8'h00, 11'd0}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_DISCARD, 11'd0, 8'h00, 11'd0}},
		'{rfs_pkg::OP_PUSH, 8'hD3, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd1}},
		'{rfs_pkg::OP_PUSH, 8'hFC, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_DISCARD, 11'd0, 8'h00, 11'd1}},
		'{rfs_pkg::OP_PUSH, 8'hD3, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_DISCARD, 11'd0, 8'h00, 11'd1}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd2}},
		'{rfs_pkg::OP_PUSH, 8'h01, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd3}},
		'{rfs_pkg::OP_PUSH, 8'hFF, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd4}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, CRC_HI, 1'b0, NO_WANT},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, CRC_MID, 1'b0, NO_WANT},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, CRC_LO, 1'b1,
			'{rfs_pkg::ST_VALID, 11'd7, 8'h00, 11'd0}},
		'{rfs_pkg::OP_READ, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_READ, 11'd0, 8'hD3, 11'd0}},
		'{rfs_pkg::OP_READ, 8'h00, 11'd3, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_READ, 11'd0, 8'hFF, 11'd0}},
		'{rfs_pkg::OP_READ, 8'h00, 11'd6, USE_BYTE, 1'b0, NO_WANT},
		'{rfs_pkg::OP_READ, 8'h00, 11'd1029, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_READ, 11'd0, 8'h00, 11'd0}},
		'{rfs_pkg::OP_PUSH, 8'hD3, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd1}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd2}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd3}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd4}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_INCOMPLETE, 11'd0, 8'h00, 11'd5}},
		'{rfs_pkg::OP_PUSH, 8'h00, 11'd0, USE_BYTE, 1'b1,
			'{rfs_pkg::ST_DISCARD, 11'd0, 8'h00, 11'd5}},
		'{rfs_pkg::OP_READ, 8'h00, 11'd4, USE_BYTE, 1'b0, NO_WANT}
	};

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        opcode;
	logic [7:0]  data_byte;
	logic [10:0] read_index;
	logic        empty;
	logic        pop;
	logic [2:0]  status;
	logic [10:0] frame_length;
	logic [7:0]  read_data;
	logic [10:0] buffer_fill;

	octet_q_t      frame_store;
	int unsigned   fill;
	int unsigned   high_water;
	rfs_pkg::res_t sync_reports_due[$];
	int unsigned   n_items;
	int unsigned   n_fail;
	int unsigned   burst_left;

	rtcm3_frame_synchronizer #(.MAX_FRAME_BYTES(MAX_BYTES)) i_dut (
		.clk,
		.arst_n,
		.push,
		.full,
		.opcode,
		.data_byte,
		.read_index,
		.empty,
		.pop,
		.status,
		.frame_length,
		.read_data,
		.buffer_fill
	);

	function automatic logic [23:0] crc24q_of(input octet_q_t bytes, input int unsigned n);
		logic [24:0] acc;
		acc = '0;
		for (int unsigned i = 0; i < n; i++) begin
			acc[23:16] = acc[23:16] ^ bytes[i];
			for (int k = 0; k < 8; k++) begin
				acc = {acc[23:0], 1'b0};
				if (acc[24]) begin
					acc[23:0] = acc[23:0] ^ rfs_pkg::CRC24Q_POLY;
				end
			end
		end
		return acc[23:0];
	endfunction

	// advances the synchroniser state by one word and returns its report
	function automatic rfs_pkg::res_t sync_on_word(input logic op, input logic [7:0] b,
			input logic [10:0] idx);
		rfs_pkg::res_t r;
		int unsigned   body_len;
		int unsigned   need;
		logic [23:0]   tail;
		r = '0;
		if (op == rfs_pkg::OP_READ) begin
			r.status = rfs_pkg::ST_READ;
			if (idx < MAX_BYTES) begin
				r.read_data = frame_store[idx];
			end
		end else if (fill >= MAX_BYTES) begin
			r.status = rfs_pkg::ST_FULL;
		end else begin
			frame_store[fill] = b;
			fill++;
			if (fill > high_water) begin
				high_water = fill;
			end
			if (frame_store[0] != rfs_pkg::SYNC_BYTE) begin
				r.status = rfs_pkg::ST_DISCARD;
			end else if (fill >= rfs_pkg::RESV_FILL &&
					(frame_store[1] & rfs_pkg::RESERVED_MASK) != 8'h00) begin
				r.status = rfs_pkg::ST_DISCARD;
			end else if (fill < rfs_pkg::FRAME_OVERHEAD) begin
				r.status = rfs_pkg::ST_INCOMPLETE;
			end else begin
				body_len = (int'(frame_store[1] & rfs_pkg::LEN_HI_MASK) << 8) | frame_store[2];
				need = body_len + rfs_pkg::FRAME_OVERHEAD;
				if (body_len == 0 || need > MAX_BYTES) begin
					r.status = rfs_pkg::ST_DISCARD;
				end else if (fill < need) begin
					r.status = rfs_pkg::ST_INCOMPLETE;
				end else begin
					tail = {frame_store[body_len + 3], frame_store[body_len + 4],
						frame_store[body_len + 5]};
					if (tail != crc24q_of(frame_store, body_len + rfs_pkg::CRC_BYTES)) begin
						r.status = rfs_pkg::ST_DISCARD;
					end else begin
						r.status = rfs_pkg::ST_VALID;
						r.frame_length = 11'(need);
					end
				end
			end
			if (r.status == rfs_pkg::ST_DISCARD) begin
				fill--;
				for (int unsigned i = 0; i < fill; i++) begin
					frame_store[i] = frame_store[i + 1];
				end
			end else if (r.status == rfs_pkg::ST_VALID) begin
				fill = 0;
			end
		end
		r.buffer_fill = 11'(fill);
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input logic op, input logic [7:0] b, input logic [10:0] idx,
			input bit typed, input rfs_pkg::res_t want);
		rfs_pkg::res_t got;
		int unsigned   gap;
		got = sync_on_word(op, b, idx);
		sync_reports_due.push_back(typed ? want : got);
		n_items++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap != 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		opcode <= op;
		data_byte <= b;
		read_index <= idx;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : drain
		int unsigned   window;
		pop_mode_t     mode;
		rfs_pkg::res_t want;
		pop = 1'b0;
		window = 0;
		mode = POP_FREE;
		forever begin
			@(negedge clk);
			if (window == 0) begin
				window = $urandom_range(8, 60);
				mode = pop_mode_t'($urandom_range(0, 3));
			end
			window--;
			case (mode)
				POP_FREE: begin
					pop <= 1'b1;
				end
				POP_HALF: begin
					pop <= 1'($urandom_range(0, 1));
				end
				POP_SPARSE: begin
					pop <= ($urandom_range(0, 5) == 0);
				end
				default: begin
					pop <= 1'b0;
				end
			endcase
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (sync_reports_due.size() == 0) begin
					$error("unrequested word: status %0d, buffer_fill %0d", status, buffer_fill);
					n_fail++;
				end else begin
					want = sync_reports_due.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						n_fail++;
					end
					if (frame_length !== want.frame_length) begin
						$error("frame_length: expected %0d, got %0d", want.frame_length,
							frame_length);
						n_fail++;
					end
					if (read_data !== want.read_data) begin
						$error("read_data: expected %0h, got %0h", want.read_data, read_data);
						n_fail++;
					end
					if (buffer_fill !== want.buffer_fill) begin
						$error("buffer_fill: expected %0d, got %0d", want.buffer_fill,
							buffer_fill);
						n_fail++;
					end
				end
			end
		end
	end

	initial begin : stimulus
		dir_row_t    row;
		logic [7:0]  b;
		logic [23:0] crc;
		octet_q_t    frame_bytes;
		int unsigned flen, n_send, pick, seq, pos, blen;
		arst_n = 1'b0;
		push = 1'b0;
		opcode = rfs_pkg::OP_PUSH;
		data_byte = 8'h00;
		read_index = 11'd0;
		n_items = 0;
		n_fail = 0;
		burst_left = 0;
		fill = 0;
		high_water = 0;
		frame_store.delete();
		repeat (MAX_BYTES) frame_store.push_back(8'h00);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			b = row.b;
			if (row.src != USE_BYTE) begin
				blen = (int'(frame_store[1] & rfs_pkg::LEN_HI_MASK) << 8) | frame_store[2];
				crc = crc24q_of(frame_store, blen + rfs_pkg::CRC_BYTES);
				case (row.src)
					CRC_HI: begin
						b = crc[23:16];
					end
					CRC_MID: begin
						b = crc[15:8];
					end
					default: begin
						b = crc[7:0];
					end
				endcase
			end
			send_word(row.op, b, row.idx, row.typed, row.want);
		end

		seq = 0;
		while (n_items < ITEM_TARGET || seq <= LONG_SEQ) begin
			pick = $urandom_range(0, 99);
			if (pick < 76 || seq == LONG_SEQ) begin
				if (seq == LONG_SEQ) begin
					flen = LONG_LEN;
				end else if ($urandom_range(0, 9) < 8) begin
					flen = $urandom_range(1, 16);
				end else begin
					flen = $urandom_range(17, 160);
				end
				frame_bytes.delete();
				frame_bytes.push_back(rfs_pkg::SYNC_BYTE);
				frame_bytes.push_back(8'(flen >> 8));
				frame_bytes.push_back(8'(flen));
				repeat (flen) frame_bytes.push_back(8'($urandom));
				crc = crc24q_of(frame_bytes, flen + rfs_pkg::CRC_BYTES);
				frame_bytes.push_back(crc[23:16]);
				frame_bytes.push_back(crc[15:8]);
				frame_bytes.push_back(crc[7:0]);
				n_send = frame_bytes.size();
				// broken frames: one byte flipped, or cut short
				if (pick >= 62 && seq != LONG_SEQ) begin
					if ($urandom_range(0, 1) == 1) begin
						pos = ($urandom_range(0, 4) == 0) ? 0 :
							$urandom_range(3, frame_bytes.size() - 1);
						frame_bytes[pos] = frame_bytes[pos] ^ 8'($urandom_range(1, 255));
					end else begin
						n_send = $urandom_range(1, frame_bytes.size() - 1);
					end
				end
				for (int unsigned i = 0; i < n_send; i++) begin
					send_word(rfs_pkg::OP_PUSH, frame_bytes[i], 11'($urandom), 1'b0, NO_WANT);
				end
			end else if (pick < 88) begin
				if ($urandom_range(0, 3) == 0) begin
					send_word(rfs_pkg::OP_PUSH, rfs_pkg::SYNC_BYTE, 11'($urandom), 1'b0, NO_WANT);
					send_word(rfs_pkg::OP_PUSH, 8'h00, 11'($urandom), 1'b0, NO_WANT);
					send_word(rfs_pkg::OP_PUSH, 8'h00, 11'($urandom), 1'b0, NO_WANT);
				end
				repeat ($urandom_range(1, 6)) begin
					b = ($urandom_range(0, 7) == 0) ? rfs_pkg::SYNC_BYTE : 8'($urandom);
					send_word(rfs_pkg::OP_PUSH, b, 11'($urandom), 1'b0, NO_WANT);
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if (high_water != 0 && $urandom_range(0, 3) != 0) begin
						pos = $urandom_range(0, high_water - 1);
					end else begin
						pos = $urandom_range(MAX_BYTES, 2047);
					end
					send_word(rfs_pkg::OP_READ, 8'($urandom), 11'(pos), 1'b0, NO_WANT);
				end
			end
			seq++;
		end
		push <= 1'b0;

		while (sync_reports_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_fail == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
